/* rtl/sdte_pkg.sv */
`default_nettype none
package sdte_pkg;

  typedef struct packed {
    logic [7:0] access_time_code;
    logic [7:0] access_clocks_code;
    logic       card_is_sd;
  } in_t;

  typedef struct packed {
    logic [2:0] timeout_multiplier;
    logic [3:0] timeout_cycles;
    logic       timeout_saturated;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic ck_mul;
    logic ck_fix;
    logic p_mul;
    logic t_mul;
    logic t_fix;
    logic base;
    logic scale;
    logic search_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic search_done;
  } status_t;

  localparam logic [24:0] ClkReset = 25'd20000000;

  // ceil(clk / 100000) by reciprocal: floor(2^43 / 100000)
  localparam logic [16:0] CkDiv    = 17'd100000;
  localparam logic [16:0] CkRound  = 17'd99999;
  localparam logic [26:0] CkRecip  = 27'd87960930;
  localparam int unsigned CkShift  = 43;

  // ceil(p / 10000) by reciprocal: floor(2^45 / 10000)
  localparam logic [13:0] TDiv     = 14'd10000;
  localparam logic [13:0] TRound   = 14'd9999;
  localparam logic [31:0] TRecip   = 32'd3518437208;
  localparam int unsigned TShift   = 45;

  localparam logic [2:0]  CodeMax   = 3'd7;
  localparam logic [3:0]  CyclesMax = 4'd15;

  localparam logic [6:0] MantTenths [16] = '{
    7'd0, 7'd10, 7'd12, 7'd13, 7'd15, 7'd20, 7'd25, 7'd30,
    7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd70, 7'd80
  };

  // ceil(mantissa / 10)
  localparam logic [3:0] MantCeil [16] = '{
    4'd0, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8
  };

  localparam logic [16:0] DecScale [6] = '{
    17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000, 17'd100000
  };

  localparam logic [4:0] ShiftOfCode [8] = '{
    5'd0, 5'd4, 5'd7, 5'd8, 5'd10, 5'd12, 5'd16, 5'd20
  };

  // ceil(ceil(exp * mant / 10) / 10), folded per exponent
  function automatic logic [22:0] ns10_of(input logic [2:0] e, input logic [3:0] m);
    logic [23:0] prod;
    prod = 24'(DecScale[3'(e - 3'd2)]) * 24'(MantTenths[m]);
    unique case (e)
      3'd0:    ns10_of = {22'd0, (m != 4'd0)};
      3'd1:    ns10_of = {19'd0, MantCeil[m]};
      default: ns10_of = prod[22:0];
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/sdte_ctrl.sv */
`default_nettype none
module sdte_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire sdte_pkg::status_t status_i,
  output sdte_pkg::cmd_t         cmd_o
);
  import sdte_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StCkMul, StCkFix, StPMul, StTMul, StTFix, StBase, StScale, StSearch
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCkMul;
        end
      end
      StCkMul: begin
        cmd_o.ck_mul = 1'b1;
        state_d      = StCkFix;
      end
      StCkFix: begin
        cmd_o.ck_fix = 1'b1;
        state_d      = StPMul;
      end
      StPMul: begin
        cmd_o.p_mul = 1'b1;
        state_d     = StTMul;
      end
      StTMul: begin
        cmd_o.t_mul = 1'b1;
        state_d     = StTFix;
      end
      StTFix: begin
        cmd_o.t_fix = 1'b1;
        state_d     = StBase;
      end
      StBase: begin
        cmd_o.base = 1'b1;
        state_d    = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StSearch;
      end
      StSearch: begin
        if (!status_i.search_done) begin
          cmd_o.search_step = 1'b1;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/sdte_dp.sv */
`default_nettype none
module sdte_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [24:0]       cfg_data_i,
  input  wire sdte_pkg::in_t     in_data_i,
  input  wire sdte_pkg::cmd_t    cmd_i,
  output sdte_pkg::status_t      status_o,
  output sdte_pkg::out_t         out_data_o
);
  import sdte_pkg::*;

  logic [24:0] clk_hz_q;
  in_t         in_q;
  logic [25:0] y_q;
  logic [22:0] ns10_q;
  logic [9:0]  ck0_q, ck_q;
  logic [31:0] z_q;
  logic [18:0] t0_q, t_q;
  logic [18:0] base_q;
  logic [24:0] clks_q;
  logic [25:0] cyc_q;
  logic [2:0]  code_q;
  out_t        out_q;

  logic [52:0] prod_ck;
  logic [26:0] ck_back;
  logic [25:0] ck_rem;
  logic [32:0] prod_p;
  logic [63:0] prod_t;
  logic [32:0] t_back;
  logic [32:0] t_rem;
  logic [24:0] scaled;
  logic [2:0]  code_nx;
  logic [19:0] mask_nx;
  logic [25:0] cyc_nx;
  logic        over;

  assign prod_ck = 53'(y_q) * 53'(CkRecip);
  assign ck_back = 27'(ck0_q) * 27'(CkDiv);
  assign ck_rem  = y_q - ck_back[25:0];
  assign prod_p  = 33'(ns10_q) * 33'(ck_q) + 33'(TRound);
  assign prod_t  = 64'(z_q) * 64'(TRecip);
  assign t_back  = 33'(t0_q) * 33'(TDiv);
  assign t_rem   = 33'(z_q) - t_back;
  assign scaled  = 25'(base_q) * (in_q.card_is_sd ? 25'd100 : 25'd10);

  assign code_nx = code_q + 3'd1;
  assign mask_nx = 20'((21'd1 << ShiftOfCode[code_nx]) - 21'd1);
  assign cyc_nx  = (26'(clks_q) + 26'(mask_nx)) >> ShiftOfCode[code_nx];

  assign over                 = (cyc_q > 26'(CyclesMax));
  assign status_o.search_done = !over || (code_q == CodeMax);
  assign out_data_o           = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q   <= in_data_i;
      y_q    <= 26'(clk_hz_q) + 26'(CkRound);
      ns10_q <= ns10_of(in_data_i.access_time_code[2:0], in_data_i.access_time_code[6:3]);
    end
    if (cmd_i.ck_mul) begin
      ck0_q <= prod_ck[CkShift +: 10];
    end
    if (cmd_i.ck_fix) begin
      ck_q <= ck0_q + 10'(ck_rem >= 26'(CkDiv));
    end
    if (cmd_i.p_mul) begin
      z_q <= prod_p[31:0];
    end
    if (cmd_i.t_mul) begin
      t0_q <= prod_t[TShift +: 19];
    end
    if (cmd_i.t_fix) begin
      t_q <= t0_q + 19'(t_rem >= 33'(TDiv));
    end
    if (cmd_i.base) begin
      base_q <= 19'(in_q.access_clocks_code) * 19'd100 + t_q;
    end
    if (cmd_i.scale) begin
      clks_q <= scaled;
      cyc_q  <= 26'(scaled);
      code_q <= 3'd0;
    end
    if (cmd_i.search_step) begin
      code_q <= code_nx;
      cyc_q  <= cyc_nx;
    end
    if (cmd_i.load_out) begin
      out_q.timeout_multiplier <= over ? CodeMax : code_q;
      out_q.timeout_cycles     <= over ? CyclesMax : cyc_q[3:0];
      out_q.timeout_saturated  <= over;
    end
  end

endmodule
`default_nettype wire

/* rtl/sd_data_timeout_encoder_top.sv */
// SD/MMC data-timeout encoder.
// Input channel (in_valid_i / in_stall_o): one request carries the CSD TAAC
// and NSAC bytes and the SD flag. A request is taken when valid is high and
// stall is low; stall is high while a request is being worked on.
// Output channel (out_valid_o / out_stall_i): one result per request, the
// multiplier code, the cycle count and the saturation flag.
// Config channel (cfg_valid_i / cfg_ready_o): card clock in Hz, always ready.
// Sequence: from acceptance the sequencer runs the clock multiply and correct,
// product multiply, time multiply and correct, base and scale steps, then up to
// 7 shift trials (one per cycle in the search step) before the result is loaded
// into the output register and out_valid_o rises.
// A finished result waits in the output register while out_stall_i is high;
// the next request is taken once that result is loaded there, and its own
// result waits in the datapath until the output register frees.
// Reset: no result pending, sequencer idle, card clock 20000000 Hz.
`default_nettype none
module sd_data_timeout_encoder_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [24:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sdte_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sdte_pkg::out_t      out_data_o
);
  import sdte_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sdte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdte_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import sdte_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam logic [24:0] CLK_MAX_25B  = 25'h1FFFFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [24:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;

  out_t        expected_timeouts[$];
  logic [24:0] card_clock_hz;
  bit          idle_on;
  bit          hold_request;
  bit          hold_active;
  int unsigned burst_left;
  int unsigned sent_count;
  int unsigned seen_count;
  int unsigned cfg_count;
  int unsigned sat_count;
  int unsigned errors;

  sd_data_timeout_encoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned exp_scale(input logic [2:0] e);
    case (e)
      3'd0: exp_scale = 1;
      3'd1: exp_scale = 10;
      3'd2: exp_scale = 100;
      3'd3: exp_scale = 1000;
      3'd4: exp_scale = 10000;
      3'd5: exp_scale = 100000;
      3'd6: exp_scale = 1000000;
      default: exp_scale = 10000000;
    endcase
  endfunction

  function automatic longint unsigned mant_tenths(input logic [3:0] m);
    case (m)
      4'd0:  mant_tenths = 0;
      4'd1:  mant_tenths = 10;
      4'd2:  mant_tenths = 12;
      4'd3:  mant_tenths = 13;
      4'd4:  mant_tenths = 15;
      4'd5:  mant_tenths = 20;
      4'd6:  mant_tenths = 25;
      4'd7:  mant_tenths = 30;
      4'd8:  mant_tenths = 35;
      4'd9:  mant_tenths = 40;
      4'd10: mant_tenths = 45;
      4'd11: mant_tenths = 50;
      4'd12: mant_tenths = 55;
      4'd13: mant_tenths = 60;
      4'd14: mant_tenths = 70;
      default: mant_tenths = 80;
    endcase
  endfunction

  function automatic int unsigned shift_of(input int unsigned code);
    case (code)
      0: shift_of = 0;
      1: shift_of = 4;
      2: shift_of = 7;
      3: shift_of = 8;
      4: shift_of = 10;
      5: shift_of = 12;
      6: shift_of = 16;
      default: shift_of = 20;
    endcase
  endfunction

  function automatic out_t predict_timeout(input in_t req, input logic [24:0] hz);
    longint unsigned ns;
    longint unsigned clks;
    longint unsigned clk_units;
    longint unsigned nsac;
    longint unsigned cyc;
    int unsigned     code;
    int unsigned     sh;
    out_t            res;
    ns        = (exp_scale(req.access_time_code[2:0])
                 * mant_tenths(req.access_time_code[6:3]) + 9) / 10;
    clk_units = 64'(hz);
    clk_units = (clk_units + 99999) / 100000;
    nsac      = 64'(req.access_clocks_code);
    clks      = nsac * 100 + (((ns + 9) / 10) * clk_units + 9999) / 10000;
    clks      = clks * (req.card_is_sd ? 100 : 10);
    cyc  = clks;
    code = 0;
    while (cyc > 15 && code < 7) begin
      code++;
      sh  = shift_of(code);
      cyc = (clks + ((64'd1 << sh) - 1)) >> sh;
    end
    res.timeout_saturated = 1'b0;
    if (cyc > 15) begin
      code = 7;
      cyc  = 15;
      res.timeout_saturated = 1'b1;
    end
    res.timeout_multiplier = code[2:0];
    res.timeout_cycles     = cyc[3:0];
    return res;
  endfunction

  function automatic in_t make_request(input logic [7:0] taac, input logic [7:0] nsac,
                                       input logic sd);
    in_t req;
    req.access_time_code   = taac;
    req.access_clocks_code = nsac;
    req.card_is_sd         = sd;
    return req;
  endfunction

  function automatic in_t random_request();
    return make_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [24:0] random_clock();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: random_clock = '0;
          1: random_clock = 25'd25000000;
          2: random_clock = CLK_MAX_25B;
          default: random_clock = 25'd1;
        endcase
      end
      1: random_clock = 25'($urandom);
      2: random_clock = 25'($urandom_range(0, 25000000));
      default: random_clock = 25'($urandom_range(0, 300000));
    endcase
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input in_t req);
    int unsigned gap;
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_timeouts.push_back(predict_timeout(req, card_clock_hz));
    sent_count++;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_request(random_request());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_timeouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_card_clock(input logic [24:0] hz);
    drain_results();
    cfg_data_i  <= hz;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    card_clock_hz = hz;
    cfg_count++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_clock();
    idle_on = 1'b0;
    send_request(make_request(8'h00, 8'h00, 1'b0));
    send_request(make_request(8'h00, 8'h00, 1'b1));
    send_request(make_request(8'h07, 8'h00, 1'b1));
    send_request(make_request(8'h7F, 8'hFF, 1'b1));
    send_request(make_request(8'hFF, 8'hFF, 1'b0));
    send_request(make_request(8'h80, 8'h01, 1'b0));
    send_request(make_request(8'h08, 8'h00, 1'b0));
    send_request(make_request(8'h2E, 8'h00, 1'b1));
    send_request(make_request(8'h3A, 8'h14, 1'b1));
    send_request(make_request(8'h00, 8'hFF, 1'b0));
    send_request(make_request(8'hC5, 8'h55, 1'b1));
    send_request(make_request(8'h01, 8'hAA, 1'b0));
    drain_results();
  endtask

  task automatic test_clock_extremes();
    write_card_clock('0);
    send_request(make_request(8'h7F, 8'h00, 1'b1));
    send_request(make_request(8'h7F, 8'hFF, 1'b1));
    write_card_clock(CLK_MAX_25B);
    send_request(make_request(8'h7F, 8'hFF, 1'b1));
    send_request(make_request(8'h7F, 8'hFF, 1'b0));
    send_request(make_request(8'h07, 8'h00, 1'b1));
    write_card_clock(25'd25000000);
    send_request(make_request(8'h7F, 8'hFF, 1'b1));
    send_request(make_request(8'h79, 8'h00, 1'b0));
    write_card_clock(25'd1);
    send_request(make_request(8'h7F, 8'h00, 1'b0));
    send_request(make_request(8'h09, 8'h00, 1'b1));
    drain_results();
  endtask

  task automatic test_clock_sweep();
    logic [24:0] sweep[7];
    sweep = '{25'd1, 25'd99999, 25'd100000, 25'd100001, 25'd25000000, CLK_MAX_25B, 25'd0};
    idle_on = 1'b1;
    foreach (sweep[i]) begin
      write_card_clock(sweep[i]);
      send_random(20);
    end
    drain_results();
  endtask

  task automatic test_output_hold_off();
    write_card_clock(25'd20000000);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    send_random(16);
    drain_results();
  endtask

  task automatic test_random_traffic();
    repeat (8) begin
      write_card_clock(random_clock());
      idle_on = $urandom_range(0, 3) != 0;
      send_random(130);
    end
    drain_results();
  endtask

  task automatic test_streaming();
    write_card_clock(random_clock());
    idle_on = 1'b0;
    send_random(100);
    drain_results();
  endtask

  // long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    forever begin
      wait (hold_request);
      @(negedge clk_i);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_active  = 1'b0;
      hold_request = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (burst_left > 0) begin
      burst_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 9);
    end
    out_stall_i <= hold_active || (burst_left > 0);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_count++;
      if (out_data_o.timeout_saturated) sat_count++;
      if (expected_timeouts.size() == 0) begin
        report_error($sformatf("unexpected result: mult %0d cycles %0d sat %0b",
                               out_data_o.timeout_multiplier, out_data_o.timeout_cycles,
                               out_data_o.timeout_saturated));
      end else begin
        want = expected_timeouts.pop_front();
        if (out_data_o.timeout_multiplier !== want.timeout_multiplier ||
            out_data_o.timeout_cycles !== want.timeout_cycles ||
            out_data_o.timeout_saturated !== want.timeout_saturated) begin
          report_error($sformatf(
            "mismatch at result %0d: exp mult/cyc/sat %0d/%0d/%0b, got %0d/%0d/%0b",
            seen_count, want.timeout_multiplier, want.timeout_cycles, want.timeout_saturated,
            out_data_o.timeout_multiplier, out_data_o.timeout_cycles,
            out_data_o.timeout_saturated));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[sd_data_timeout_encoder_top] ERROR");
    $finish;
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    idle_on       = 1'b0;
    hold_request  = 1'b0;
    burst_left    = 0;
    sent_count    = 0;
    seen_count    = 0;
    cfg_count     = 0;
    sat_count     = 0;
    errors        = 0;
    card_clock_hz = 25'd20000000;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_clock();
    test_clock_extremes();
    test_clock_sweep();
    test_output_hold_off();
    test_random_traffic();
    test_streaming();

    $display("covered %0d requests and %0d results over %0d card clock writes,",
             sent_count, seen_count, cfg_count);
    $display("%0d saturated results, random stalls and a %0d-cycle output hold-off",
             sat_count, HOLD_CYCLES);
    if (errors == 0) begin
      $display("[sd_data_timeout_encoder_top] OK");
    end else begin
      $display("[sd_data_timeout_encoder_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sdte_pkg.sv
rtl/sdte_ctrl.sv
rtl/sdte_dp.sv
rtl/sd_data_timeout_encoder_top.sv
tb/sv/testbench.sv
